// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by deadline_timer_queue.sv
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition implies another on the next edge
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/dtq_pkg.sv -----
// package for the deadline timer queue: payload types and result kinds
// depends on nothing
package dtq_pkg;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  localparam logic ACTION_SCHEDULE = 1'b0;
  localparam logic ACTION_TICK     = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] deadline;
    logic [15:0] task_id;
    logic [63:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] released_task;
    logic [63:0] released_deadline;
    logic        rejected;
    logic [63:0] next_deadline;
    logic [6:0]  occupancy;
    logic        last;
  } out_item_t;

endpackage

// ----- hw/rtl/deadline_timer_queue.sv -----
// deadline timer queue: bounded min-heap of timer entries in one memory
// depends on dtq_pkg and assert_macros.svh
// an insert into an empty heap goes to the root, else the entry climbs a parent at a time
// until it settles or reaches the root; a tick with nothing due answers with no release,
// each release sifts the last entry down from the root; one request at a time, paced by
// the single read port; synchronous reset empties the heap and zeroes the insert sequence
`include "assert_macros.svh"

module deadline_timer_queue #(
  parameter int HEAP_DEPTH   = 64,
  parameter int TASK_ID_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dtq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dtq_pkg::out_item_t out_data
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  typedef struct packed {
    logic [63:0]             dl;
    logic [TASK_ID_BITS-1:0] tid;
    logic [31:0]             tag;
  } entry_t;

  // states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPRD  = 4'd1;
  localparam logic [3:0] S_UPCMP = 4'd2;
  localparam logic [3:0] S_TRD   = 4'd3;
  localparam logic [3:0] S_TCHK  = 4'd4;
  localparam logic [3:0] S_LRD   = 4'd5;
  localparam logic [3:0] S_LGET  = 4'd6;
  localparam logic [3:0] S_RGET  = 4'd7;
  localparam logic [3:0] S_DNCMP = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_MVRD  = 4'd10;
  localparam logic [3:0] S_MVGET = 4'd11;

  // heap memory, one write and one read port
  entry_t           mem [HEAP_DEPTH];
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // control and working registers
  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [31:0]   seq;
  logic [AW-1:0] pos;
  entry_t        cur;
  entry_t        lch;
  logic          has_l;
  logic          has_r;
  logic [63:0]   now;
  logic          released;
  entry_t        root;
  entry_t        rel;
  logic          rel_last;
  logic          ob_valid;
  dtq_pkg::out_item_t ob;

  function automatic logic precedes(entry_t a, entry_t b);
    logic [31:0] d;
    d = b.tag - a.tag;
    if (a.dl != b.dl) return a.dl < b.dl;
    return (d != 32'd0) && !d[31];
  endfunction

  // child indices one bit wider than the address, parent index at the address width
  logic [AW:0]   lidx;
  logic [AW:0]   ridx;
  logic [AW-1:0] parent;
  assign lidx   = {pos, 1'b1};
  assign ridx   = {pos, 1'b0} + (AW+1)'(2);
  assign parent = (pos - {{(AW-1){1'b0}}, 1'b1}) >> 1;

  logic          full;
  assign full     = (count == CW'(HEAP_DEPTH));
  assign in_ready = (state == S_IDLE) && !ob_valid;
  assign out_valid = ob_valid;
  assign out_data  = ob;

  entry_t        best;
  logic          l_win;
  logic          r_win;
  always_comb begin
    l_win = has_l && precedes(lch, cur);
    best  = l_win ? lch : cur;
    r_win = has_r && precedes(rd_data, best);
  end

  // main sequencer
  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      seq      <= '0;
      ob_valid <= 1'b0;
      released <= 1'b0;
    end else begin
      if (ob_valid && out_ready) ob_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            now      <= in_data.current_time;
            released <= 1'b0;
            if (in_data.action == dtq_pkg::ACTION_SCHEDULE) begin
              if (full) begin
                ob_valid <= 1'b1;
                ob <= '{kind: dtq_pkg::KIND_ACK, released_task: '0,
                        released_deadline: '0, rejected: 1'b1,
                        next_deadline: root.dl, occupancy: 7'(count), last: 1'b1};
              end else begin
                cur   <= '{dl: in_data.deadline,
                           tid: TASK_ID_BITS'(in_data.task_id), tag: seq};
                seq   <= seq + 32'd1;
                pos   <= AW'(count);
                count <= count + 1'b1;
                if (count == '0) begin
                  root     <= '{dl: in_data.deadline,
                                tid: TASK_ID_BITS'(in_data.task_id), tag: seq};
                  wr_en    <= 1'b1;
                  wr_addr  <= '0;
                  wr_data  <= '{dl: in_data.deadline,
                                tid: TASK_ID_BITS'(in_data.task_id), tag: seq};
                  ob_valid <= 1'b1;
                  ob <= '{kind: dtq_pkg::KIND_ACK, released_task: '0,
                          released_deadline: '0, rejected: 1'b0,
                          next_deadline: in_data.deadline, occupancy: 7'(count + 1'b1),
                          last: 1'b1};
                end else begin
                  state <= S_UPRD;
                end
              end
            end else begin
              state <= S_TCHK;
            end
          end
        end
        // sift up: read parent
        S_UPRD: begin
          rd_addr <= parent;
          state   <= S_MVGET;
        end
        S_MVGET: begin
          state <= S_UPCMP;
        end
        S_UPCMP: begin
          wr_en <= 1'b1;
          if (precedes(cur, rd_data)) begin
            wr_addr <= pos;
            wr_data <= rd_data;
            pos     <= parent;
            if (parent == '0) begin
              wr_en    <= 1'b1;
              state    <= S_EMIT;
              root     <= cur;
            end else begin
              state <= S_UPRD;
            end
          end else begin
            wr_addr <= pos;
            wr_data <= cur;
            state   <= S_IDLE;
            ob_valid <= 1'b1;
            ob <= '{kind: dtq_pkg::KIND_ACK, released_task: '0,
                    released_deadline: '0, rejected: 1'b0,
                    next_deadline: root.dl, occupancy: 7'(count), last: 1'b1};
          end
        end
        // final write of a climbed entry into the root
        S_EMIT: begin
          if (released) begin
            state <= S_TCHK;
          end else begin
            wr_en    <= 1'b1;
            wr_addr  <= '0;
            wr_data  <= cur;
            state    <= S_IDLE;
            ob_valid <= 1'b1;
            ob <= '{kind: dtq_pkg::KIND_ACK, released_task: '0,
                    released_deadline: '0, rejected: 1'b0,
                    next_deadline: cur.dl, occupancy: 7'(count), last: 1'b1};
          end
        end
        // tick: decide whether the root is due, output waits for buffer
        S_TCHK: begin
          if (!ob_valid || out_ready) begin
            if (count != '0 && root.dl <= now) begin
              rel      <= root;
              count    <= count - 1'b1;
              released <= 1'b1;
              rd_addr  <= AW'(count - 1'b1);
              state    <= S_TRD;
            end else if (!released) begin
              ob_valid <= 1'b1;
              ob <= '{kind: dtq_pkg::KIND_NONE, released_task: '0,
                      released_deadline: '0, rejected: 1'b0,
                      next_deadline: (count == '0) ? '1 : root.dl,
                      occupancy: 7'(count), last: 1'b1};
              state <= S_IDLE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        // last entry read, it becomes the sinking entry
        S_TRD: begin
          state <= S_MVRD;
        end
        S_MVRD: begin
          cur <= rd_data;
          pos <= '0;
          if (count == '0) begin
            rel_last <= 1'b1;
            state    <= S_RGET;
          end else begin
            rel_last <= 1'b0;
            state    <= S_LRD;
          end
        end
        // sift down: read left child then right child
        S_LRD: begin
          has_l   <= (lidx < (AW+1)'(count));
          has_r   <= (ridx < (AW+1)'(count));
          rd_addr <= lidx[AW-1:0];
          state   <= S_LGET;
        end
        S_LGET: begin
          rd_addr <= ridx[AW-1:0];
          state   <= S_DNCMP;
        end
        S_DNCMP: begin
          lch   <= rd_data;
          state <= S_RGET;
        end
        S_RGET: begin
          if (rel_last) begin
            // heap drained or settled: send the release
            if (!ob_valid || out_ready) begin
              ob_valid <= 1'b1;
              ob <= '{kind: dtq_pkg::KIND_RELEASE,
                      released_task: 16'(rel.tid), released_deadline: rel.dl,
                      rejected: 1'b0,
                      next_deadline: (count == '0) ? '1 : root.dl,
                      occupancy: 7'(count),
                      last: (count == '0) || !(root.dl <= now)};
              state <= S_TCHK;
            end
          end else begin
            wr_en <= 1'b1;
            if (r_win) begin
              wr_addr <= pos;
              wr_data <= rd_data;
              if (pos == '0) root <= rd_data;
              pos     <= ridx[AW-1:0];
              state   <= S_LRD;
            end else if (l_win) begin
              wr_addr <= pos;
              wr_data <= lch;
              if (pos == '0) root <= lch;
              pos     <= lidx[AW-1:0];
              state   <= S_LRD;
            end else begin
              wr_addr  <= pos;
              wr_data  <= cur;
              if (pos == '0) root <= cur;
              rel_last <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `CHK_ALWAYS(a_occ_bound, clk, rst, count <= CW'(HEAP_DEPTH), "occupancy beyond depth")
  `CHK_ALWAYS(a_ready_idle, clk, rst, !in_ready || (state == S_IDLE), "ready while busy")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data),
            "result dropped while stalled")

endmodule
